FILE: rtl/qvr_pkg.sv
// shared types and constants for the quaternion vector rotator
package qvr_pkg;

    localparam int QUAT_W  = 16;
    localparam int POINT_W = 24;
    localparam int PROD_W  = 2 * QUAT_W;        // one quaternion product
    localparam int MENT_W  = PROD_W + 3;        // one rotation matrix entry
    localparam int NORM_W  = PROD_W + 1;        // squared norm
    localparam int MUL_W   = MENT_W + POINT_W;  // matrix entry times coordinate
    localparam int SUM_W   = MUL_W + 3;         // dot product of one row
    localparam int MAG_W   = SUM_W;
    localparam int NUM_W   = MAG_W + 2;         // 2*|sum| + norm
    localparam int DEN_W   = NORM_W + 1;        // 2*norm

    localparam int LAT_MAT  = 2;
    localparam int LAT_MAC  = 2;
    localparam int LAT_DIV  = POINT_W + 2;
    localparam int PIPE_LAT = LAT_MAT + LAT_MAC + LAT_DIV;

    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam logic [1:0] REG_QUAT_W = 2'd0;
    localparam logic [1:0] REG_QUAT_X = 2'd1;
    localparam logic [1:0] REG_QUAT_Y = 2'd2;
    localparam logic [1:0] REG_QUAT_Z = 2'd3;

    localparam logic signed [QUAT_W-1:0] QUAT_ONE = QUAT_W'(1 << (QUAT_W - 2));

    typedef logic signed [MENT_W-1:0] t_ment;
    typedef logic signed [SUM_W-1:0]  t_sum;

    typedef struct packed {
        logic signed [QUAT_W-1:0] quat_w;
        logic signed [QUAT_W-1:0] quat_x;
        logic signed [QUAT_W-1:0] quat_y;
        logic signed [QUAT_W-1:0] quat_z;
    } t_quat;

    typedef struct packed {
        logic signed [POINT_W-1:0] point_x;
        logic signed [POINT_W-1:0] point_y;
        logic signed [POINT_W-1:0] point_z;
    } t_point;

    typedef struct packed {
        logic signed [POINT_W-1:0] rotated_x;
        logic signed [POINT_W-1:0] rotated_y;
        logic signed [POINT_W-1:0] rotated_z;
        logic                      saturated;
    } t_rot;

    typedef struct packed {
        t_ment [8:0]       m;
        logic [NORM_W-1:0] den;
    } t_mat;

    typedef struct packed {
        t_sum [2:0]        s;
        logic [NORM_W-1:0] den;
    } t_dot;

    typedef struct packed {
        logic signed [POINT_W-1:0] value;
        logic                      clip;
    } t_coord;

endpackage

FILE: rtl/qvr_matrix.sv
// quaternion products and rotation matrix, two stages
module qvr_matrix (
    input  logic            i_clk,
    input  logic            i_en,
    input  qvr_pkg::t_quat  i_quat,
    input  qvr_pkg::t_point i_point,
    output qvr_pkg::t_mat   o_mat,
    output qvr_pkg::t_point o_point
);
    import qvr_pkg::*;

    function automatic t_ment ext(input logic signed [PROD_W-1:0] p);
        ext = MENT_W'(p);
    endfunction

    logic signed [PROD_W-1:0] r_ww, r_xx, r_yy, r_zz, r_xy, r_xz, r_yz, r_wx, r_wy, r_wz;
    t_point r_pt1, r_pt2;
    t_mat   n_mat, r_mat;
    logic [NORM_W-1:0] n_norm;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ww  <= i_quat.quat_w * i_quat.quat_w;
            r_xx  <= i_quat.quat_x * i_quat.quat_x;
            r_yy  <= i_quat.quat_y * i_quat.quat_y;
            r_zz  <= i_quat.quat_z * i_quat.quat_z;
            r_xy  <= i_quat.quat_x * i_quat.quat_y;
            r_xz  <= i_quat.quat_x * i_quat.quat_z;
            r_yz  <= i_quat.quat_y * i_quat.quat_z;
            r_wx  <= i_quat.quat_w * i_quat.quat_x;
            r_wy  <= i_quat.quat_w * i_quat.quat_y;
            r_wz  <= i_quat.quat_w * i_quat.quat_z;
            r_pt1 <= i_point;
            r_mat <= n_mat;
            r_pt2 <= r_pt1;
        end
    end

    always_comb begin
        n_mat.m[0] = ext(r_ww) + ext(r_xx) - ext(r_yy) - ext(r_zz);
        n_mat.m[1] = (ext(r_xy) - ext(r_wz)) <<< 1;
        n_mat.m[2] = (ext(r_xz) + ext(r_wy)) <<< 1;
        n_mat.m[3] = (ext(r_xy) + ext(r_wz)) <<< 1;
        n_mat.m[4] = ext(r_ww) - ext(r_xx) + ext(r_yy) - ext(r_zz);
        n_mat.m[5] = (ext(r_yz) - ext(r_wx)) <<< 1;
        n_mat.m[6] = (ext(r_xz) - ext(r_wy)) <<< 1;
        n_mat.m[7] = (ext(r_yz) + ext(r_wx)) <<< 1;
        n_mat.m[8] = ext(r_ww) - ext(r_xx) - ext(r_yy) + ext(r_zz);
        // squares are never negative
        n_norm = NORM_W'(unsigned'(r_ww)) + NORM_W'(unsigned'(r_xx))
               + NORM_W'(unsigned'(r_yy)) + NORM_W'(unsigned'(r_zz));
        // zero quaternion divides by one
        n_mat.den = (n_norm == '0) ? NORM_W'(1) : n_norm;
    end

    assign o_mat   = r_mat;
    assign o_point = r_pt2;

endmodule

FILE: rtl/qvr_mac.sv
// matrix times point, products then row sums
module qvr_mac (
    input  logic            i_clk,
    input  logic            i_en,
    input  qvr_pkg::t_mat   i_mat,
    input  qvr_pkg::t_point i_point,
    output qvr_pkg::t_dot   o_dot
);
    import qvr_pkg::*;

    logic signed [MUL_W-1:0] r_p [9];
    logic [NORM_W-1:0]       r_den;
    t_dot                    r_dot;
    logic signed [POINT_W-1:0] v [3];

    assign v[0] = i_point.point_x;
    assign v[1] = i_point.point_y;
    assign v[2] = i_point.point_z;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 9; k++) begin
                r_p[k] <= i_mat.m[k] * v[k % 3];
            end
            r_den <= i_mat.den;
            for (int r = 0; r < 3; r++) begin
                r_dot.s[r] <= SUM_W'(r_p[3*r]) + SUM_W'(r_p[3*r+1]) + SUM_W'(r_p[3*r+2]);
            end
            r_dot.den <= r_den;
        end
    end

    assign o_dot = r_dot;

endmodule

FILE: rtl/qvr_div.sv
// rounded divide of one coordinate by the norm, one quotient bit a stage
module qvr_div (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  qvr_pkg::t_sum              i_sum,
    input  logic [qvr_pkg::NORM_W-1:0] i_den,
    output qvr_pkg::t_coord            o_coord
);
    import qvr_pkg::*;

    logic [MAG_W-1:0] mag;
    logic [NUM_W-1:0] r_num;
    logic [DEN_W-1:0] r_d0;
    logic             r_neg0;

    logic [NUM_W-1:0]   r_rem [POINT_W+1];
    logic [POINT_W-1:0] r_q   [POINT_W+1];
    logic [DEN_W-1:0]   r_d   [POINT_W+1];
    logic               r_neg [POINT_W+1];
    logic               r_ovf [POINT_W+1];

    assign mag = i_sum[SUM_W-1] ? MAG_W'(-i_sum) : MAG_W'(i_sum);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num  <= {1'b0, mag, 1'b0} + NUM_W'(i_den);
            r_d0   <= {i_den, 1'b0};
            r_neg0 <= i_sum[SUM_W-1];
            // quotient of 2^POINT_W or more always clips
            r_ovf[0] <= r_num >= (NUM_W'(r_d0) << POINT_W);
            r_rem[0] <= r_num;
            r_q[0]   <= '0;
            r_d[0]   <= r_d0;
            r_neg[0] <= r_neg0;
        end
    end

    for (genvar i = 0; i < POINT_W; i++) begin : g_step
        localparam int B = POINT_W - 1 - i;
        logic [NUM_W-1:0] sh;
        logic             take;
        assign sh   = NUM_W'(r_d[i]) << B;
        assign take = r_rem[i] >= sh;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[i+1] <= take ? r_rem[i] - sh : r_rem[i];
                r_q[i+1]   <= r_q[i] | (POINT_W'(take) << B);
                r_d[i+1]   <= r_d[i];
                r_neg[i+1] <= r_neg[i];
                r_ovf[i+1] <= r_ovf[i];
            end
        end
    end

    localparam logic [POINT_W-1:0] HALF = POINT_W'(1) << (POINT_W - 1);

    always_comb begin
        o_coord.clip  = 1'b0;
        o_coord.value = '0;
        if (r_neg[POINT_W]) begin
            if (r_ovf[POINT_W] || r_q[POINT_W] > HALF) begin
                o_coord.clip  = 1'b1;
                o_coord.value = HALF;
            end else begin
                o_coord.value = -r_q[POINT_W];
            end
        end else begin
            if (r_ovf[POINT_W] || r_q[POINT_W] > HALF - 1'b1) begin
                o_coord.clip  = 1'b1;
                o_coord.value = HALF - 1'b1;
            end else begin
                o_coord.value = r_q[POINT_W];
            end
        end
    end

endmodule

FILE: rtl/quaternion_vector_rotate_top.sv
// quaternion point rotator: config registers, pipeline control and output register
//
//  channel  direction  handshake          payload
//  point    in         i_valid / o_stall  i_point (t_point)
//  rotated  out        o_valid / i_stall  o_rot (t_rot)
//  config   in         apb psel/penable   quat_w, quat_x, quat_y, quat_z
//
// one point a cycle sustained while the output is not stalled; the pipeline runs through the
// matrix, the row products, the bit-per-stage divider by the norm and an output register.
// reset clears valid bits and loads the identity quaternion.
// a stalled output beat freezes the whole pipeline, so nothing is lost or repeated.
module quaternion_vector_rotate_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  qvr_pkg::t_point            i_point,
    output logic                       o_valid,
    input  logic                       i_stall,
    output qvr_pkg::t_rot              o_rot,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [qvr_pkg::ADDR_W-1:0] paddr,
    input  logic [qvr_pkg::DATA_W-1:0] pwdata,
    output logic [qvr_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);
    import qvr_pkg::*;

    t_quat  r_quat;
    logic [PIPE_LAT-1:0] r_vld;
    logic   r_out_vld;
    t_rot   r_rot;
    logic   en;
    t_mat   mat;
    t_point pt;
    t_dot   dot;
    t_coord crd [3];

    assign pready  = 1'b1;
    assign o_stall = r_out_vld && i_stall;
    assign en      = !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quat.quat_w <= QUAT_ONE;
            r_quat.quat_x <= '0;
            r_quat.quat_y <= '0;
            r_quat.quat_z <= '0;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_QUAT_W: r_quat.quat_w <= pwdata[QUAT_W-1:0];
                REG_QUAT_X: r_quat.quat_x <= pwdata[QUAT_W-1:0];
                REG_QUAT_Y: r_quat.quat_y <= pwdata[QUAT_W-1:0];
                REG_QUAT_Z: r_quat.quat_z <= pwdata[QUAT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_QUAT_W: prdata = DATA_W'(r_quat.quat_w);
            REG_QUAT_X: prdata = DATA_W'(r_quat.quat_x);
            REG_QUAT_Y: prdata = DATA_W'(r_quat.quat_y);
            REG_QUAT_Z: prdata = DATA_W'(r_quat.quat_z);
            default:    prdata = '0;
        endcase
    end

    qvr_matrix u_matrix (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_quat  (r_quat),
        .i_point (i_point),
        .o_mat   (mat),
        .o_point (pt)
    );

    qvr_mac u_mac (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_mat   (mat),
        .i_point (pt),
        .o_dot   (dot)
    );

    for (genvar c = 0; c < 3; c++) begin : g_div
        qvr_div u_div (
            .i_clk   (i_clk),
            .i_en    (en),
            .i_sum   (dot.s[c]),
            .i_den   (dot.den),
            .o_coord (crd[c])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_vld     <= {r_vld[PIPE_LAT-2:0], i_valid};
            r_out_vld <= r_vld[PIPE_LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rot.rotated_x <= crd[0].value;
            r_rot.rotated_y <= crd[1].value;
            r_rot.rotated_z <= crd[2].value;
            r_rot.saturated <= crd[0].clip || crd[1].clip || crd[2].clip;
        end
    end

    assign o_valid = r_out_vld;
    assign o_rot   = r_rot;

    localparam logic signed [POINT_W-1:0] PMAX = POINT_W'((1 << (POINT_W - 1)) - 1);
    localparam logic signed [POINT_W-1:0] PMIN = ~PMAX;

    a_stall_only_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid) else $error("stall raised with no output beat");

    a_sat_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rot.saturated) |->
        (o_rot.rotated_x == PMAX || o_rot.rotated_x == PMIN ||
         o_rot.rotated_y == PMAX || o_rot.rotated_y == PMIN ||
         o_rot.rotated_z == PMAX || o_rot.rotated_z == PMIN))
        else $error("saturated flag without a clipped coordinate");

    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> $stable(r_vld)) else $error("pipeline moved during stall");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid) else $error("output valid after reset");

endmodule

FILE: test/qvr_checker.sv
// checker for the quaternion rotator: tracks the registers, predicts each point and compares
module qvr_checker
    import qvr_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic                o_stall,
    input  t_point              i_point,
    input  logic                o_valid,
    input  logic                i_stall,
    input  t_rot                o_rot,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    input  logic                pready,
    output int                  o_fail_count,
    output int                  o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    t_quat quat;
    t_rot  rotated_q[$];

    // round half away from zero, clip to the point range
    function automatic logic [POINT_W-1:0] round_clip(longint num, longint unsigned den,
                                                       inout bit clip);
        bit              neg;
        longint unsigned mag;
        longint unsigned quo;
        longint unsigned half;
        longint          val;
        neg  = num < 0;
        mag  = neg ? longint'(-num) : longint'(num);
        quo  = (2 * mag + den) / (2 * den);
        half = 64'd1 << (POINT_W - 1);
        if (neg) begin
            if (quo > half) begin
                quo  = half;
                clip = 1'b1;
            end
            val = -longint'(quo);
        end else begin
            if (quo > half - 1) begin
                quo  = half - 1;
                clip = 1'b1;
            end
            val = longint'(quo);
        end
        return val[POINT_W-1:0];
    endfunction

    function automatic t_rot rotate_point(t_quat q, t_point p);
        longint w, x, y, z, vx, vy, vz;
        longint ww, xx, yy, zz, xy, xz, yz, wx, wy, wz;
        longint sx, sy, sz;
        longint unsigned norm;
        bit     clip;
        t_rot   r;
        w  = q.quat_w;  x  = q.quat_x;  y  = q.quat_y;  z  = q.quat_z;
        vx = p.point_x; vy = p.point_y; vz = p.point_z;
        ww = w * w; xx = x * x; yy = y * y; zz = z * z;
        xy = x * y; xz = x * z; yz = y * z;
        wx = w * x; wy = w * y; wz = w * z;
        sx = (ww + xx - yy - zz) * vx + 2 * (xy - wz) * vy + 2 * (xz + wy) * vz;
        sy = 2 * (xy + wz) * vx + (ww - xx + yy - zz) * vy + 2 * (yz - wx) * vz;
        sz = 2 * (xz - wy) * vx + 2 * (yz + wx) * vy + (ww - xx - yy + zz) * vz;
        norm = ww + xx + yy + zz;
        // zero quaternion divides by one
        if (norm == 0) norm = 1;
        clip = 1'b0;
        r.rotated_x = round_clip(sx, norm, clip);
        r.rotated_y = round_clip(sy, norm, clip);
        r.rotated_z = round_clip(sz, norm, clip);
        r.saturated = clip;
        return r;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
        o_fail_count++;
    endtask

    initial begin
        o_fail_count = 0;
    end

    assign o_pending = rotated_q.size();

    always @(posedge i_clk) begin
        t_rot want;
        if (!i_rst_n) begin
            quat.quat_w <= QUAT_ONE;
            quat.quat_x <= '0;
            quat.quat_y <= '0;
            quat.quat_z <= '0;
            rotated_q.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_QUAT_W: quat.quat_w <= pwdata[QUAT_W-1:0];
                    REG_QUAT_X: quat.quat_x <= pwdata[QUAT_W-1:0];
                    REG_QUAT_Y: quat.quat_y <= pwdata[QUAT_W-1:0];
                    REG_QUAT_Z: quat.quat_z <= pwdata[QUAT_W-1:0];
                    default: ;
                endcase
            end
            if (i_valid && !o_stall) rotated_q.push_back(rotate_point(quat, i_point));
            if (o_valid && !i_stall) begin
                if (rotated_q.size() == 0) begin
                    $display("unexpected output beat at %0t", $realtime);
                    o_fail_count++;
                end else begin
                    want = rotated_q.pop_front();
                    if (o_rot.rotated_x !== want.rotated_x)
                        report_mismatch("rotated_x", o_rot.rotated_x, want.rotated_x);
                    if (o_rot.rotated_y !== want.rotated_y)
                        report_mismatch("rotated_y", o_rot.rotated_y, want.rotated_y);
                    if (o_rot.rotated_z !== want.rotated_z)
                        report_mismatch("rotated_z", o_rot.rotated_z, want.rotated_z);
                    if (o_rot.saturated !== want.saturated)
                        report_mismatch("saturated", o_rot.saturated, want.saturated);
                end
            end
        end
    end

endmodule

FILE: test/tb_quaternion_vector_rotate_top.sv
// testbench top for the quaternion rotator: stimulus, receiver stalls and verdict
module tb_quaternion_vector_rotate_top;
    import qvr_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 5000;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    t_point             i_point;
    logic               o_valid;
    logic               i_stall;
    t_rot               o_rot;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [ADDR_W-1:0]  paddr;
    logic [DATA_W-1:0]  pwdata;
    logic [DATA_W-1:0]  prdata;
    logic               pready;
    int                 fail_count;
    int                 pending;
    bit                 hold_req;
    int                 burst_left;
    int                 idle_cycles;

    quaternion_vector_rotate_top u_dut (.*);

    qvr_checker u_checker (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_point, .o_valid, .i_stall, .o_rot,
        .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_point = '0;
        i_stall = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        hold_req = 1'b0;
        burst_left = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // receiver stall pattern from a randomly chosen mode, plus a forced stall on hold_req
    initial begin
        int mode;
        int cnt;
        mode = 0;
        cnt  = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_stall <= 1'b1;
                repeat (300) @(posedge i_clk);
                hold_req = 1'b0;
            end
            cnt++;
            if (cnt % 64 == 0) mode = $urandom_range(0, 3);
            case (mode)
                0: i_stall <= 1'b0;
                1: i_stall <= ($urandom_range(0, 3) == 0);
                2: i_stall <= ($urandom_range(0, 9) < 7);
                default: i_stall <= (cnt % 5) < 2;
            endcase
        end
    end

    // no progress watchdog
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || psel || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_quaternion_vector_rotate_top: FAIL");
            $finish;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [QUAT_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= {DATA_W'($urandom) >> QUAT_W << QUAT_W} | DATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic load_quat(logic [QUAT_W-1:0] w, logic [QUAT_W-1:0] x,
                             logic [QUAT_W-1:0] y, logic [QUAT_W-1:0] z);
        write_reg(REG_QUAT_W, w);
        write_reg(REG_QUAT_X, x);
        write_reg(REG_QUAT_Y, y);
        write_reg(REG_QUAT_Z, z);
    endtask

    // one point beat, bursts with random gaps in between
    task automatic send_point(t_point p);
        if (burst_left == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 8)) @(posedge i_clk);
            burst_left = $urandom_range(1, 30);
        end
        i_valid <= 1'b1;
        i_point <= p;
        do @(posedge i_clk); while (o_stall);
        burst_left--;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    function automatic logic [POINT_W-1:0] rand_coord();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 6) return POINT_W'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
        if (sel < 8) return POINT_W'($urandom);
        case ($urandom_range(0, 3))
            0: return {1'b1, {(POINT_W-1){1'b0}}};
            1: return {1'b0, {(POINT_W-1){1'b1}}};
            2: return '0;
            default: return '1;
        endcase
    endfunction

    initial begin
        t_point p;
        logic [POINT_W-1:0] edge_vals[5];
        edge_vals = '{24'h800000, 24'h7fffff, 24'h000000, 24'hffffff, 24'h010000};
        @(posedge i_rst_n);
        @(posedge i_clk);
        // directed: identity after reset, then the zero quaternion and extremes of the quaternion
        for (int k = 0; k < 25; k++) begin
            p.point_x = edge_vals[k % 5];
            p.point_y = edge_vals[(k / 5) % 5];
            p.point_z = edge_vals[(k + 2) % 5];
            send_point(p);
            if (k == 9) begin
                drain();
                // zero quaternion gives zero output
                load_quat('0, '0, '0, '0);
            end
            if (k == 17) begin
                drain();
                load_quat(16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
            end
        end
        drain();
        for (int ph = 0; ph < 9; ph++) begin
            case (ph)
                0: load_quat(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
                1: load_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
                2: load_quat(16'h2d41, 16'h0000, 16'h0000, 16'h2d41);
                3: load_quat(16'h0000, 16'h4000, 16'h0000, 16'h0000);
                4: load_quat(QUAT_ONE, '0, '0, '0);
                default: load_quat(QUAT_W'($urandom), QUAT_W'($urandom),
                                   QUAT_W'($urandom), QUAT_W'($urandom));
            endcase
            if (ph == 2) hold_req = 1'b1;
            for (int k = 0; k < 103; k++) begin
                p.point_x = rand_coord();
                p.point_y = rand_coord();
                p.point_z = rand_coord();
                send_point(p);
            end
            drain();
        end
        repeat (PIPE_LAT + 10) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_quaternion_vector_rotate_top: PASS");
        end else begin
            $display("tb_quaternion_vector_rotate_top: FAIL");
        end
        $finish;
    end

endmodule
